### rtl/lwi_pkg.sv
// Shared types and constants for the looped waypoint interpolator.
package lwi_pkg;

  // Dividend width of the restoring divider chain; one cell per dividend bit
  localparam int DIVIDEND_W = 64;

  localparam int SLOT_W     = 6;
  localparam int DELAY_W    = 31;
  localparam int COUNT_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY_OFFSET   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYPOINT_COUNT = 2'd1;

  // Input word kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NEG_RD,
    ST_NEG_TAKE,
    ST_PER_RD,
    ST_PER_TAKE,
    ST_MOD_WAIT,
    ST_WALK,
    ST_FRAC_WAIT,
    ST_LERP_X,
    ST_LERP_Y,
    ST_LERP_DONE,
    ST_RESULT
  } lwi_state_t;

endpackage

### rtl/lwi_div_cell.sv
// One restoring division step, registered, handing its word to the next cell.
module lwi_div_cell #(
  parameter int VW = 32,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [VW-1:0] in_rem,
  input  logic [VW-1:0] in_dvs,
  input  logic [DW-1:0] in_dvd,
  output logic          out_vld,
  output logic [VW-1:0] out_rem,
  output logic [VW-1:0] out_dvs,
  output logic [DW-1:0] out_dvd
);

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_next;
  logic [DW-1:0] dvd_next;

  // Shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    trial    = {in_rem, in_dvd[DW-1]};
    diff     = trial - {1'b0, in_dvs};
    ge       = (trial >= {1'b0, in_dvs});
    rem_next = ge ? diff[VW-1:0] : trial[VW-1:0];
    dvd_next = {in_dvd[DW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_rem <= rem_next;
    out_dvs <= in_dvs;
    out_dvd <= dvd_next;
  end

endmodule

### rtl/lwi_div_chain.sv
// Row of divider cells, one registered division step each; quotient and remainder come from the last cell.
module lwi_div_chain #(
  parameter int VW = 32,
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_vld,
  input  logic [VW-1:0] in_dvs,
  input  logic [DW-1:0] in_dvd,
  output logic          out_vld,
  output logic [VW-1:0] out_rem,
  output logic [DW-1:0] out_quo
);

  logic          vld [DW+1];
  logic [VW-1:0] rem [DW+1];
  logic [VW-1:0] dvs [DW+1];
  logic [DW-1:0] dvd [DW+1];

  // Feed the first cell with a cleared remainder
  assign vld[0] = in_vld;
  assign rem[0] = '0;
  assign dvs[0] = in_dvs;
  assign dvd[0] = in_dvd;

  for (genvar g = 0; g < DW; g++) begin : g_cell
    lwi_div_cell #(.VW(VW), .DW(DW)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_vld  (vld[g]),
      .in_rem  (rem[g]),
      .in_dvs  (dvs[g]),
      .in_dvd  (dvd[g]),
      .out_vld (vld[g+1]),
      .out_rem (rem[g+1]),
      .out_dvs (dvs[g+1]),
      .out_dvd (dvd[g+1])
    );
  end

  assign out_vld = vld[DW];
  assign out_rem = rem[DW];
  assign out_quo = dvd[DW];

endmodule

### rtl/looped_waypoint_interpolator.sv
// Top level: waypoint table, query sequencer, divider chain and interpolation multiplier.
//
//  channel | handshake          | payload
//  --------+--------------------+------------------------------------------------------
//  s_      | s_tvalid/s_tready  | tuser: mode; tdata: slot, time, point xyz, base xyz
//  m_      | m_tvalid/m_tready  | tuser: valid_res; tdata: base xyz, actor xyz
//  cfg_    | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A waypoint write is taken in the idle state, and the next word can follow at once. A query
// compares table entries one a cycle through the memory port and passes up to twice
// through the 64-cell divider chain, which sets most of its time. A query before start or
// with a zero period skips the divider and goes straight to its result.
// One word is processed at a time; a finished word waits in the output register while
// the next input word is already taken. Reset clears control state only; the table
// holds whatever was written.
module looped_waypoint_interpolator #(
  parameter int MAX_WAYPOINTS = 64,
  parameter int VALUE_WIDTH   = 32
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  // tdata: slot, time_value, point_x, point_y, point_z, base_x, base_y, base_z
  input  logic [((lwi_pkg::SLOT_W+7*VALUE_WIDTH+7)/8)*8-1:0] s_tdata,
  // tuser: mode
  input  logic                                     s_tuser,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  // tdata: out_base_x, out_base_y, out_base_z, actor_x, actor_y, actor_z
  output logic [((6*VALUE_WIDTH+7)/8)*8-1:0]       m_tdata,
  // tuser: valid_res
  output logic                                     m_tuser,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [lwi_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [lwi_pkg::CFG_DATA_W-1:0]           cfg_data
);
  import lwi_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int DW    = DIVIDEND_W;
  localparam int FRAC  = DW - VW;
  localparam int AW    = $clog2(MAX_WAYPOINTS);
  localparam int OUT_W = ((6*VW+7)/8)*8;
  localparam int TW    = ((VW > DELAY_W + 1) ? VW : DELAY_W + 1) + 1;

  // Configuration registers
  logic [DELAY_W-1:0] delay_offset;
  logic [COUNT_W-1:0] waypoint_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_offset   <= '0;
      waypoint_count <= COUNT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_DELAY_OFFSET) begin
        delay_offset <= cfg_data[DELAY_W-1:0];
      end else if (cfg_index == CFG_WAYPOINT_COUNT) begin
        waypoint_count <= cfg_data[COUNT_W-1:0];
      end
    end
  end

  // Input word fields
  logic [SLOT_W-1:0] in_slot;
  logic [VW-1:0]     in_time, in_px, in_py, in_pz, in_bx, in_by, in_bz;

  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_time = s_tdata[SLOT_W       +: VW];
  assign in_px   = s_tdata[SLOT_W+VW    +: VW];
  assign in_py   = s_tdata[SLOT_W+2*VW  +: VW];
  assign in_pz   = s_tdata[SLOT_W+3*VW  +: VW];
  assign in_bx   = s_tdata[SLOT_W+4*VW  +: VW];
  assign in_by   = s_tdata[SLOT_W+5*VW  +: VW];
  assign in_bz   = s_tdata[SLOT_W+6*VW  +: VW];

  lwi_state_t state, state_next;

  logic accept;
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // Start-delay subtraction and count clamp, evaluated at accept
  logic [TW-1:0] t_full;
  int            clamp_cnt;
  logic [AW-1:0] last_sel;

  assign t_full = $signed({{(TW-VW){in_time[VW-1]}}, in_time})
                - $signed({{(TW-DELAY_W){1'b0}}, delay_offset});

  always_comb begin
    clamp_cnt = int'(waypoint_count);
    if (clamp_cnt == 0) clamp_cnt = 1;
    if (clamp_cnt > MAX_WAYPOINTS) clamp_cnt = MAX_WAYPOINTS;
    last_sel = AW'(clamp_cnt - 1);
  end

  // Waypoint table: {z, y, x, time} per entry
  logic [4*VW-1:0] table_mem [MAX_WAYPOINTS];
  logic [4*VW-1:0] rdata;
  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [VW-1:0]   rd_t, rd_x, rd_y, rd_z;

  assign wr_en = accept && (s_tuser == MODE_WRITE) && (int'(in_slot) < MAX_WAYPOINTS);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[AW'(in_slot)] <= {in_pz, in_py, in_px, in_time};
    end
    rdata <= table_mem[rd_addr];
  end

  assign rd_t = rdata[0    +: VW];
  assign rd_x = rdata[VW   +: VW];
  assign rd_y = rdata[2*VW +: VW];
  assign rd_z = rdata[3*VW +: VW];

  // Query registers
  logic          t_neg;
  logic [VW-1:0] t_val;
  logic [VW-1:0] tm;
  logic [AW-1:0] last_idx;
  logic [VW-1:0] base_x, base_y, base_z;
  logic [AW-1:0] idx, cmp_idx;
  logic          cmp_valid;
  logic [VW-1:0] prev_t, prev_x, prev_y;
  logic [VW-1:0] v0x, v0y, v1x, v1y;
  logic [FRAC-1:0] frac;
  logic [DW-1:0] prod;
  logic          res_vld;
  logic [VW-1:0] res_x, res_y, res_z;

  // Divider chain
  logic          div_in_vld, div_out_vld;
  logic [VW-1:0] div_in_dvs, div_out_rem;
  logic [DW-1:0] div_in_dvd, div_out_quo;

  lwi_div_chain #(.VW(VW), .DW(DW)) u_div (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (div_in_vld),
    .in_dvs  (div_in_dvs),
    .in_dvd  (div_in_dvd),
    .out_vld (div_out_vld),
    .out_rem (div_out_rem),
    .out_quo (div_out_quo)
  );

  // Period, walk compare and segment spans
  logic [VW-1:0] period;
  logic [VW:0]   num_w, den_w;
  logic          found, at_end;

  assign period = rd_t[VW-1] ? (~rd_t + VW'(1)) : rd_t;
  assign found  = cmp_valid && ($signed(tm) < $signed(rd_t));
  assign at_end = (cmp_idx == last_idx);
  assign num_w  = {tm[VW-1], tm} - {prev_t[VW-1], prev_t};
  assign den_w  = {rd_t[VW-1], rd_t} - {prev_t[VW-1], prev_t};

  // Interpolation step magnitudes and signs
  logic [VW:0]   dx, dy;
  logic [VW-1:0] mag_x, mag_y, mul_a;
  logic [VW-1:0] step;

  assign dx    = {v1x[VW-1], v1x} - {v0x[VW-1], v0x};
  assign dy    = {v1y[VW-1], v1y} - {v0y[VW-1], v0y};
  assign mag_x = dx[VW] ? VW'(-dx) : dx[VW-1:0];
  assign mag_y = dy[VW] ? VW'(-dy) : dy[VW-1:0];
  assign mul_a = (state == ST_LERP_X) ? mag_x : mag_y;
  assign step  = prod[DW-1:FRAC];

  logic load_out;
  assign load_out = (state == ST_RESULT) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, memory address and divider feed
  always_comb begin
    state_next = state;
    rd_addr    = '0;
    div_in_vld = 1'b0;
    div_in_dvs = period;
    div_in_dvd = {{(DW-VW){1'b0}}, t_val};
    unique case (state)
      ST_IDLE: begin
        if (accept && (s_tuser == MODE_QUERY)) begin
          state_next = t_full[TW-1] ? ST_NEG_RD : ST_PER_RD;
        end
      end
      ST_NEG_RD: state_next = ST_NEG_TAKE;
      ST_NEG_TAKE: state_next = ST_RESULT;
      ST_PER_RD: begin
        rd_addr    = last_idx;
        state_next = ST_PER_TAKE;
      end
      ST_PER_TAKE: begin
        if (period == '0) begin
          state_next = ST_RESULT;
        end else begin
          div_in_vld = 1'b1;
          state_next = ST_MOD_WAIT;
        end
      end
      ST_MOD_WAIT: begin
        if (div_out_vld) state_next = ST_WALK;
      end
      ST_WALK: begin
        rd_addr = idx;
        if (found) begin
          if (cmp_idx == '0) begin
            state_next = ST_RESULT;
          end else begin
            div_in_vld = 1'b1;
            div_in_dvs = den_w[VW-1:0];
            div_in_dvd = {num_w[VW-1:0], {FRAC{1'b0}}};
            state_next = ST_FRAC_WAIT;
          end
        end else if (cmp_valid && at_end) begin
          state_next = ST_RESULT;
        end
      end
      ST_FRAC_WAIT: begin
        if (div_out_vld) state_next = ST_LERP_X;
      end
      ST_LERP_X: state_next = ST_LERP_Y;
      ST_LERP_Y: state_next = ST_LERP_DONE;
      ST_LERP_DONE: state_next = ST_RESULT;
      ST_RESULT: begin
        if (load_out) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Query datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * frac;
    unique case (state)
      ST_IDLE: begin
        t_neg    <= t_full[TW-1];
        t_val    <= t_full[VW-1:0];
        last_idx <= last_sel;
        base_x   <= in_bx;
        base_y   <= in_by;
        base_z   <= in_bz;
        res_vld  <= 1'b0;
        res_x    <= '0;
        res_y    <= '0;
        res_z    <= '0;
      end
      ST_NEG_TAKE: begin
        res_vld <= 1'b1;
        res_x   <= rd_x;
        res_y   <= rd_y;
        res_z   <= rd_z;
      end
      ST_MOD_WAIT: begin
        tm        <= div_out_rem;
        idx       <= '0;
        cmp_idx   <= '0;
        cmp_valid <= 1'b0;
      end
      ST_WALK: begin
        cmp_valid <= 1'b1;
        cmp_idx   <= idx;
        if (idx != last_idx) idx <= idx + AW'(1);
        prev_t <= rd_t;
        prev_x <= rd_x;
        prev_y <= rd_y;
        v0x    <= prev_x;
        v0y    <= prev_y;
        v1x    <= rd_x;
        v1y    <= rd_y;
        if (found && cmp_idx == '0) begin
          res_vld <= 1'b1;
          res_x   <= rd_x;
          res_y   <= rd_y;
        end
      end
      ST_FRAC_WAIT: begin
        frac <= div_out_quo[FRAC-1:0];
      end
      ST_LERP_Y: begin
        res_x <= dx[VW] ? (v0x - step) : (v0x + step);
      end
      ST_LERP_DONE: begin
        res_vld <= 1'b1;
        res_y   <= dy[VW] ? (v0y - step) : (v0y + step);
      end
      default: begin
      end
    endcase
  end

  // Output register: hold the word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tuser <= res_vld;
      m_tdata <= res_vld ? OUT_W'({res_z, res_y, res_x, base_z, base_y, base_x}) : '0;
    end
  end

  // Divider results only arrive while the sequencer waits for them
  assert property (@(posedge clk) disable iff (rst)
    div_out_vld |-> (state == ST_MOD_WAIT || state == ST_FRAC_WAIT))
    else $error("divider result outside a wait state");

  // An invalid result carries all-zero fields
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> (m_tdata == '0))
    else $error("invalid result with nonzero fields");

  // A finished query is presented on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    load_out |=> (m_tvalid && state == ST_IDLE))
    else $error("result not presented");

  // Negative time never enters the table walk
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !t_neg)
    else $error("walk started before start time");

endmodule

### bench/tb_top.sv
// Testbench for the looped waypoint interpolator: directed table, random phases, scoreboard.
`timescale 1ns / 100ps

module tb_top;
  import lwi_pkg::*;

  localparam int VW          = 32;
  localparam int NWP         = 64;
  localparam int S_W         = ((SLOT_W + 7*VW + 7)/8)*8;
  localparam int M_W         = ((6*VW + 7)/8)*8;
  localparam int SETTLE      = 250;
  localparam int CYCLE_LIMIT = 4000000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd2;

  typedef enum logic [1:0] {ROW_WRITE, ROW_QUERY, ROW_CFG} row_kind_t;

  typedef struct {
    logic        mode;
    logic [5:0]  slot;
    logic [31:0] tv, px, py, pz, bx, by, bz;
  } wp_word_t;

  typedef struct {
    logic        ok;
    logic [31:0] bx, by, bz, ax, ay, az;
  } position_t;

  typedef struct {
    row_kind_t kind;
    wp_word_t  w;
    bit        has_exp;
    position_t exp;
  } dir_row_t;

  logic           clk = 1'b0;
  logic           rst;
  logic           s_tvalid;
  logic           s_tready;
  logic [S_W-1:0] s_tdata;
  logic           s_tuser;
  logic           m_tvalid;
  logic           m_tready;
  logic [M_W-1:0] m_tdata;
  logic           m_tuser;
  logic           cfg_valid;
  logic           cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Shadow of the block's table and registers
  longint          wp_time[NWP];
  longint          wp_x[NWP];
  longint          wp_y[NWP];
  longint          wp_z[NWP];
  logic [30:0]     delay_reg;
  logic [6:0]      count_reg;

  position_t       pending_positions[$];
  dir_row_t        dir[$];
  int              errors = 0;
  int              cycles = 0;
  int              src_idle = 0;
  int              snk_stall = 0;

  looped_waypoint_interpolator dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Step toward v1 by the fraction f, truncating the step toward zero
  function automatic longint lerp_axis(longint v0, longint v1, longint unsigned f);
    longint          d;
    longint unsigned mag;
    longint unsigned stp;
    d   = v1 - v0;
    mag = (d < 0) ? longint'(-d) : d;
    stp = (mag * f) >> (64 - VW);
    return (d < 0) ? v0 - longint'(stp) : v0 + longint'(stp);
  endfunction

  // Expected position for a query word against the shadow table
  function automatic position_t locate_actor(wp_word_t w);
    position_t       r;
    int              n;
    longint          t, h, tp, ti, ax, ay, az;
    longint unsigned per, num, den, frac;
    bit              hit;
    r   = '{default: '0};
    hit = 1'b0;
    ax  = 0;
    ay  = 0;
    az  = 0;
    n   = (count_reg == 0) ? 1 : ((count_reg > NWP) ? NWP : int'(count_reg));
    t   = longint'(signed'(w.tv)) - longint'({33'd0, delay_reg});
    if (t < 0) begin
      hit = 1'b1;
      ax  = wp_x[0];
      ay  = wp_y[0];
      az  = wp_z[0];
    end else begin
      h   = wp_time[n-1];
      per = (h < 0) ? longint'(-h) : h;
      if (per != 0) begin
        t = longint'(longint'(t) % longint'(per));
        for (int i = 0; i < n && !hit; i++) begin
          ti = wp_time[i];
          if (t < ti) begin
            hit = 1'b1;
            if (i == 0) begin
              ax = wp_x[0];
              ay = wp_y[0];
            end else begin
              tp   = wp_time[i-1];
              num  = t - tp;
              den  = ti - tp;
              frac = (num << (64 - VW)) / den;
              ax   = lerp_axis(wp_x[i-1], wp_x[i], frac);
              ay   = lerp_axis(wp_y[i-1], wp_y[i], frac);
            end
          end
        end
      end
    end
    if (hit) begin
      r.ok = 1'b1;
      r.bx = w.bx;
      r.by = w.by;
      r.bz = w.bz;
      r.ax = ax[31:0];
      r.ay = ay[31:0];
      r.az = az[31:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // Output side: check each accepted word, then pick the next stall
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        report_mismatch("unexpected word", {31'd0, m_tuser}, 32'd0);
      end else begin
        position_t e;
        e = pending_positions.pop_front();
        if (m_tuser !== e.ok)              report_mismatch("valid_res", {31'd0, m_tuser}, {31'd0, e.ok});
        if (m_tdata[31:0]    !== e.bx)     report_mismatch("out_base_x", m_tdata[31:0], e.bx);
        if (m_tdata[63:32]   !== e.by)     report_mismatch("out_base_y", m_tdata[63:32], e.by);
        if (m_tdata[95:64]   !== e.bz)     report_mismatch("out_base_z", m_tdata[95:64], e.bz);
        if (m_tdata[127:96]  !== e.ax)     report_mismatch("actor_x", m_tdata[127:96], e.ax);
        if (m_tdata[159:128] !== e.ay)     report_mismatch("actor_y", m_tdata[159:128], e.ay);
        if (m_tdata[191:160] !== e.az)     report_mismatch("actor_z", m_tdata[191:160], e.az);
      end
    end
    m_tready <= ($urandom_range(99) >= snk_stall);
  end

  // Present one word, hold until taken, then update the shadow state
  task automatic send_word(wp_word_t w, bit has_exp, position_t exp);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= w.mode;
    s_tdata  <= {2'd0, w.bz, w.by, w.bx, w.pz, w.py, w.px, w.tv, w.slot};
    do @(posedge clk); while (!s_tready);
    if (w.mode == MODE_WRITE) begin
      wp_time[w.slot]    = longint'(signed'(w.tv));
      wp_x[w.slot]       = longint'(signed'(w.px));
      wp_y[w.slot]       = longint'(signed'(w.py));
      wp_z[w.slot]       = longint'(signed'(w.pz));
    end else begin
      pending_positions.insert(pending_positions.size(), has_exp ? exp : locate_actor(w));
    end
  endtask

  // Drop valid, wait for every result, then let the block settle
  task automatic quiesce();
    s_tvalid <= 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_DELAY_OFFSET)        delay_reg = data[30:0];
    else if (idx == CFG_WAYPOINT_COUNT) count_reg = data[6:0];
  endtask

  // Append one directed row
  task automatic add_row(dir_row_t r);
    dir.insert(dir.size(), r);
  endtask

  function automatic dir_row_t mk(row_kind_t k, logic [5:0] slot, logic [31:0] tv,
                                  logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  logic [31:0] bx, logic [31:0] by, logic [31:0] bz);
    dir_row_t r;
    r.kind    = k;
    r.w.mode  = (k == ROW_QUERY) ? MODE_QUERY : MODE_WRITE;
    r.w.slot  = slot;
    r.w.tv    = tv;
    r.w.px    = px;
    r.w.py    = py;
    r.w.pz    = pz;
    r.w.bx    = bx;
    r.w.by    = by;
    r.w.bz    = bz;
    r.has_exp = 1'b0;
    r.exp     = '{default: '0};
    return r;
  endfunction

  function automatic dir_row_t with_exp(dir_row_t r, logic ok, logic [31:0] ax,
                                        logic [31:0] ay, logic [31:0] az);
    r.has_exp = 1'b1;
    r.exp     = '{ok, ok ? r.w.bx : 32'd0, ok ? r.w.by : 32'd0, ok ? r.w.bz : 32'd0,
                  ax, ay, az};
    return r;
  endfunction

  function automatic wp_word_t rand_word(logic mode, logic [5:0] slot, logic [31:0] tv);
    wp_word_t w;
    w.mode = mode;
    w.slot = slot;
    w.tv   = tv;
    w.px   = $urandom;
    w.py   = $urandom;
    w.pz   = $urandom;
    w.bx   = $urandom;
    w.by   = $urandom;
    w.bz   = $urandom;
    return w;
  endfunction

  // One random phase: mostly sorted tables with queries around the loop, plus noise
  task automatic run_phase(int n_items);
    int              done, eff, nq, r;
    logic [6:0]      cnt;
    logic [31:0]     dly;
    longint          acc, per, qt;
    position_t       none;
    none = '{default: '0};
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(99);
      if (r < 70)      cnt = 7'($urandom_range(2, 8));
      else if (r < 78) cnt = 7'd1;
      else if (r < 88) cnt = 7'd64;
      else if (r < 94) cnt = 7'd127;
      else             cnt = 7'd0;
      eff = (cnt == 0) ? 1 : ((cnt > NWP) ? NWP : int'(cnt));
      // Lay out the table, mostly in rising time order
      acc = ($urandom_range(3) == 0) ? 0 : $urandom_range(0, 32'h20000);
      for (int i = 0; i < eff; i++) begin
        if ($urandom_range(9) == 0) send_word(rand_word(MODE_WRITE, 6'(i), $urandom), 0, none);
        else                        send_word(rand_word(MODE_WRITE, 6'(i), 32'(acc)), 0, none);
        acc += $urandom_range(1, 32'h40000);
        done++;
      end
      write_reg(CFG_WAYPOINT_COUNT, {25'd0, cnt});
      r = $urandom_range(9);
      if (r == 0)      dly = 32'h7fffffff;
      else if (r < 4)  dly = 32'd0;
      else if (r < 8)  dly = $urandom_range(0, 32'h80000);
      else             dly = $urandom;
      if ($urandom_range(1) == 0) write_reg(CFG_DELAY_OFFSET, dly);
      per = wp_time[eff-1] < 0 ? -wp_time[eff-1] : wp_time[eff-1];
      nq  = $urandom_range(8, 24);
      for (int q = 0; q < nq; q++) begin
        r = $urandom_range(99);
        if (r < 10) begin
          send_word(rand_word(MODE_WRITE, 6'($urandom), $urandom), 0, none);
        end else if (r < 20) begin
          send_word(rand_word(MODE_QUERY, 6'($urandom), $urandom), 0, none);
        end else begin
          qt = longint'({33'd0, delay_reg}) - $urandom_range(0, 32'h8000)
               + $urandom_range(0, 32'h7fff) * (3*per + 1) / 32'h7fff;
          send_word(rand_word(MODE_QUERY, 6'($urandom), qt[31:0]), 0, none);
        end
        done++;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= MODE_WRITE;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DELAY_OFFSET;
    cfg_data  <= '0;
    delay_reg = '0;
    count_reg = 7'd1;
    for (int i = 0; i < NWP; i++) begin
      wp_time[i]    = 0;
      wp_x[i]       = 0;
      wp_y[i]       = 0;
      wp_z[i]       = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows: reset state, before start, zero period, segments, extremes
    add_row(mk(ROW_WRITE, 6'd0, 32'h00010000, 32'h7fffffff, 32'h80000000,
               32'h12345678, 0, 0, 0));
    add_row(with_exp(mk(ROW_QUERY, 6'd63, 32'h80000000, 0, 0, 0, 32'h7fffffff,
               32'h80000000, 32'hffffffff), 1'b1, 32'h7fffffff, 32'h80000000,
               32'h12345678));
    add_row(with_exp(mk(ROW_QUERY, 6'd0, 32'h00010000, 0, 0, 0, 32'h80000000,
               32'h7fffffff, 32'd0), 1'b1, 32'h7fffffff, 32'h80000000, 32'd0));
    add_row(mk(ROW_WRITE, 6'd0, 32'd0, 32'd0, 32'd0, 32'd1, 0, 0, 0));
    add_row(with_exp(mk(ROW_QUERY, 6'd0, 32'd5, 0, 0, 0, 32'h1, 32'h2, 32'h3),
               1'b0, 32'd0, 32'd0, 32'd0));
    add_row(mk(ROW_WRITE, 6'd1, 32'h00020000, 32'h7fffffff, 32'h80000000, 32'd7, 0, 0, 0));
    add_row(mk(ROW_WRITE, 6'd2, 32'h00040000, 32'h80000000, 32'h7fffffff, 32'd9, 0, 0, 0));
    add_row(mk(ROW_WRITE, 6'd63, 32'hffffffff, 32'hffffffff, 32'hffffffff,
               32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff));
    add_row(mk(ROW_CFG, 6'(CFG_WAYPOINT_COUNT), 32'd3, 0, 0, 0, 0, 0, 0));
    add_row(mk(ROW_QUERY, 6'd0, 32'h00010000, 0, 0, 0, 32'h11, 32'h22, 32'h33));
    add_row(mk(ROW_QUERY, 6'd0, 32'h0003ffff, 0, 0, 0, 32'h44, 32'h55, 32'h66));
    add_row(mk(ROW_QUERY, 6'd0, 32'h7fffffff, 0, 0, 0, 32'h77, 32'h88, 32'h99));
    add_row(mk(ROW_CFG, 6'(CFG_DELAY_OFFSET), 32'h7fffffff, 0, 0, 0, 0, 0, 0));
    add_row(mk(ROW_QUERY, 6'd0, 32'h7fffffff, 0, 0, 0, 32'ha, 32'hb, 32'hc));
    add_row(with_exp(mk(ROW_QUERY, 6'd0, 32'd0, 0, 0, 0, 32'hd, 32'he, 32'hf),
               1'b1, 32'd0, 32'd0, 32'd1));
    add_row(mk(ROW_CFG, 6'(CFG_UNUSED_IDX), 32'hffffffff, 0, 0, 0, 0, 0, 0));
    add_row(mk(ROW_WRITE, 6'd1, 32'hfffffffb, 32'd100, 32'd200, 32'd0, 0, 0, 0));
    add_row(mk(ROW_QUERY, 6'd0, 32'h7fffffff, 0, 0, 0, 32'h1, 32'h1, 32'h1));
    add_row(mk(ROW_WRITE, 6'd2, 32'hfffffff0, 32'd5, 32'd6, 32'd0, 0, 0, 0));
    add_row(with_exp(mk(ROW_QUERY, 6'd0, 32'h7fffffff, 0, 0, 0, 32'h5, 32'h6, 32'h7),
               1'b0, 32'd0, 32'd0, 32'd0));
    add_row(mk(ROW_CFG, 6'(CFG_DELAY_OFFSET), 32'd0, 0, 0, 0, 0, 0, 0));
    add_row(mk(ROW_CFG, 6'(CFG_WAYPOINT_COUNT), 32'd0, 0, 0, 0, 0, 0, 0));
    add_row(mk(ROW_QUERY, 6'd0, 32'h00001234, 0, 0, 0, 32'h9, 32'h8, 32'h7));

    foreach (dir[i]) begin
      if (dir[i].kind == ROW_CFG)
        write_reg(CFG_IDX_W'(dir[i].w.slot), dir[i].w.tv);
      else
        send_word(dir[i].w, dir[i].has_exp, dir[i].exp);
    end

    // Random phases across idle and stall mixes
    run_phase(340);
    quiesce();
    src_idle = 82;
    run_phase(330);
    quiesce();
    src_idle  = 0;
    snk_stall = 82;
    run_phase(330);
    quiesce();
    src_idle  = 32;
    snk_stall = 32;
    run_phase(330);

    quiesce();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/lwi_pkg.sv
rtl/lwi_div_cell.sv
rtl/lwi_div_chain.sv
rtl/looped_waypoint_interpolator.sv
bench/tb_top.sv
